/* sv/mct_pkg.sv */
package mct_pkg;

    localparam int KEY_PORT_WIDTH  = 32;
    localparam int AMOUNT_WIDTH    = 16;
    localparam int KEY_COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH     = 24;

    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        REQ_ADD        = 2'd0,
        REQ_REMOVE     = 2'd1,
        REQ_REMOVE_ALL = 2'd2,
        REQ_QUERY      = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t                 req_type;
        logic [KEY_PORT_WIDTH-1:0] item_key;
        logic [AMOUNT_WIDTH-1:0]   amount;
    } req_t;

    typedef struct packed {
        logic                       flag;
        logic [KEY_COUNT_WIDTH-1:0] key_count;
        logic [TOTAL_WIDTH-1:0]     total_items;
        logic                       bag_empty;
        logic                       table_full;
    } rsp_t;

endpackage

/* sv/mct_req_if.sv */
interface mct_req_if;
    import mct_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

/* sv/mct_rsp_if.sv */
interface mct_rsp_if;
    import mct_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

/* sv/mct_match.sv */
module mct_match #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic [KEY_BITS-1:0] keys [ENTRIES],
    input  logic [ENTRIES-1:0]  valid,
    input  logic [KEY_BITS-1:0] key,
    output logic [ENTRIES-1:0]  hit_vec,
    output logic [ENTRIES-1:0]  free_vec
);
    import mct_pkg::*;

    // parallel key compare against every live entry
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid[i] && (keys[i] == key);
        end
    end

    // lowest clear valid bit, one-hot
    assign free_vec = ~valid & (valid + ENTRIES'(1));

endmodule

/* sv/mct_table.sv */
module mct_table #(
    parameter int ENTRIES     = 16,
    parameter int KEY_BITS    = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  mct_pkg::req_t req,
    output mct_pkg::rsp_t result
);
    import mct_pkg::*;

    localparam int AW = (COUNT_WIDTH > AMOUNT_WIDTH) ? COUNT_WIDTH : AMOUNT_WIDTH;
    localparam int SW = ((COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [KEY_BITS-1:0]    key_reg [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;
    logic [ENTRIES-1:0]     valid_next;
    logic [COUNT_WIDTH-1:0] count_reg [ENTRIES];
    logic [COUNT_WIDTH-1:0] count_next [ENTRIES];
    logic [TOTAL_WIDTH-1:0] total_reg;
    logic [TOTAL_WIDTH-1:0] total_next;

    logic [KEY_BITS-1:0]    key;
    logic [ENTRIES-1:0]     hit_vec;
    logic [ENTRIES-1:0]     free_vec;
    logic [ENTRIES-1:0]     key_we;
    logic                   hit;
    logic                   free_avail;
    logic [COUNT_WIDTH-1:0] old_cnt;
    logic [AW-1:0]          amt_ext;
    logic [COUNT_WIDTH-1:0] add_amt;
    logic [COUNT_WIDTH:0]   add_sum;
    logic [COUNT_WIDTH-1:0] add_new;
    logic [COUNT_WIDTH-1:0] add_delta;
    logic [COUNT_WIDTH-1:0] rem_amt;
    logic [COUNT_WIDTH-1:0] rem_new;
    logic [SW-1:0]          tot_sum;
    logic [SW-1:0]          tot_diff;
    logic [TOTAL_WIDTH-1:0] tot_add;
    logic [TOTAL_WIDTH-1:0] tot_sub;
    logic                   flag;
    logic                   full;
    logic [COUNT_WIDTH-1:0] cnt;

    assign key = req.item_key[KEY_BITS-1:0];

    mct_match #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_match (
        .keys     (key_reg),
        .valid    (valid_reg),
        .key      (key),
        .hit_vec  (hit_vec),
        .free_vec (free_vec)
    );

    assign hit        = |hit_vec;
    assign free_avail = |free_vec;

    // keys are unique among live entries, so the hit vector is one-hot or zero
    always_comb
    begin
        old_cnt = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            old_cnt = old_cnt | (hit_vec[i] ? count_reg[i] : '0);
        end
    end

    // add path, count saturates
    assign amt_ext   = AW'(req.amount);
    assign add_amt   = (amt_ext > AW'(COUNT_MAX)) ? COUNT_MAX : amt_ext[COUNT_WIDTH-1:0];
    assign add_sum   = {1'b0, old_cnt} + {1'b0, add_amt};
    assign add_new   = add_sum[COUNT_WIDTH] ? COUNT_MAX : add_sum[COUNT_WIDTH-1:0];
    assign add_delta = hit ? (add_new - old_cnt) : add_amt;

    // remove path, count clamps at zero
    assign rem_amt = ((req.req_type == REQ_REMOVE_ALL) || (amt_ext > AW'(old_cnt))) ?
                     old_cnt : amt_ext[COUNT_WIDTH-1:0];
    assign rem_new = old_cnt - rem_amt;

    // running total, saturating up and clamped at zero down
    assign tot_sum  = SW'(total_reg) + SW'(add_delta);
    assign tot_add  = (tot_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[TOTAL_WIDTH-1:0];
    assign tot_diff = SW'(total_reg) - SW'(rem_amt);
    assign tot_sub  = (SW'(rem_amt) >= SW'(total_reg)) ? '0 : tot_diff[TOTAL_WIDTH-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        total_next = total_reg;
        key_we     = '0;
        flag       = 1'b0;
        full       = 1'b0;
        cnt        = '0;
        case (req.req_type) inside
            REQ_ADD:
            begin
                if (hit)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit_vec[i])
                        begin
                            count_next[i] = add_new;
                        end
                    end
                    total_next = tot_add;
                    cnt        = add_new;
                end
                else
                begin
                    flag = 1'b1;
                    if (add_amt != '0)
                    begin
                        if (!free_avail)
                        begin
                            full = 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                            begin
                                if (free_vec[i])
                                begin
                                    valid_next[i] = 1'b1;
                                    count_next[i] = add_amt;
                                end
                            end
                            key_we     = free_vec;
                            total_next = tot_add;
                            cnt        = add_amt;
                        end
                    end
                end
            end
            REQ_REMOVE, REQ_REMOVE_ALL:
            begin
                if (hit)
                begin
                    flag = 1'b1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit_vec[i])
                        begin
                            count_next[i] = rem_new;
                            if (rem_new == '0)
                            begin
                                valid_next[i] = 1'b0;
                            end
                        end
                    end
                    total_next = tot_sub;
                    cnt        = rem_new;
                end
            end
            REQ_QUERY:
            begin
                if (hit)
                begin
                    flag = 1'b1;
                    cnt  = old_cnt;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.flag        = flag;
    assign result.key_count   = KEY_COUNT_WIDTH'(cnt);
    assign result.total_items = total_next;
    assign result.bag_empty   = (total_next == '0);
    assign result.table_full  = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
            total_reg <= total_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (fire && key_we[i])
            begin
                key_reg[i] <= key;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("key matches more than one live entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> (total_reg == '0))
        else $error("empty table with nonzero total");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (req.req_type == REQ_QUERY)) |=> ($stable(valid_reg) && $stable(total_reg)))
        else $error("query changed table state");

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_live_count
        assert property (@(posedge clk) disable iff (!rst_n)
            valid_reg[g] |-> (count_reg[g] != '0))
            else $error("live entry holds zero count");
    end

endmodule

/* sv/multiset_count_table.sv */
// Bounded multiset counter. Each request word adds, removes, removes all of, or
// queries one key, and exactly one response word comes back for it, in order.
// Up to ENTRIES distinct keys are held with a COUNT_WIDTH count each; counts and
// the 24-bit total saturate, and an add of a nonzero amount of a new key with the
// table full is refused with table_full set. One request is taken per clock while
// the output register is free or draining: it is held in an input register,
// looked up against every entry at once, and the table and total are updated
// in that same cycle, so the next request sees the result. Responses sit in an
// output register; while one waits for ready, the next request waits in req_reg.
module multiset_count_table #(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    mct_req_if.sink   req,
    mct_rsp_if.source rsp
);
    import mct_pkg::*;

    localparam int KEY_BITS = (KEY_WIDTH < KEY_PORT_WIDTH) ? KEY_WIDTH : KEY_PORT_WIDTH;

    logic stage_valid_reg;
    req_t req_reg;
    logic out_valid_reg;
    rsp_t rsp_reg;
    rsp_t result;
    logic fire;

    // request stage moves on when the output register is free or being drained
    assign fire      = stage_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !stage_valid_reg || fire;

    mct_table #(
        .ENTRIES     (ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .req    (req_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                stage_valid_reg <= req.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.data;
        end
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !fire) |=> (stage_valid_reg && $stable(req_reg)))
        else $error("waiting request lost or overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_reg.table_full) |-> rsp_reg.flag)
        else $error("refused add without absent-key flag");

endmodule
